// ===== rtl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Shared types and constants for the tick queue, the sequencer and the top.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // Command codes carried in the input tuser field
  typedef enum logic [1:0] {
    OpStart = 2'd0,
    OpStop  = 2'd1,
    OpWrite = 2'd2,
    OpRead  = 2'd3
  } op_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgHalfPeriod = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgAckPoll    = 4'd1;

  // Register reset values
  localparam logic [15:0] HalfPeriodRst = 16'd5;
  localparam logic [7:0]  AckPollRst    = 8'd32;

  // Stream widths
  localparam int unsigned InDataW  = 16;
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutDataW = 16;

  // Result bit positions inside the output tdata
  localparam int unsigned BusyBit = 2;
  localparam int unsigned DoneBit = 3;

  // Tick queue depth
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QLvlW  = $clog2(QDepth + 1);

  // One timing tick as classified by the front end
  typedef struct packed {
    logic       cmd;
    op_e        op;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } tick_t;

  // One result, scl_out in the lowest bit
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       status;
    logic       done_res;
    logic       busy_res;
    logic       sda_out;
    logic       scl_out;
  } res_t;

  // Queue status seen by the top level
  typedef struct packed {
    logic [QLvlW-1:0] level;
    logic             full;
  } q_stat_t;

endpackage

// ===== rtl/i2cm_front.sv =====
// ----------------------------------------------------------------------------
// I2C master tick front end
// Accepts input ticks, decodes command and line fields, and holds them in a
// short queue that the sequencer drains at its own pace.
// ----------------------------------------------------------------------------
module i2cm_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // tdata: tx_byte[7:0], send_ack[8], sda_in[9], zero fill [15:10]
  input  logic [i2cm_pkg::InDataW-1:0] s_axis_tdata,
  // tuser: cmd_valid[0], operation[2:1]
  input  logic [i2cm_pkg::InUserW-1:0] s_axis_tuser,
  output i2cm_pkg::tick_t              tick_o,
  output logic                         tick_valid_o,
  input  logic                         pop_i,
  output i2cm_pkg::q_stat_t            stat_o
);
  import i2cm_pkg::*;

  tick_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QLvlW-1:0] level_q;
  logic             full;
  logic             push;
  tick_t            tick_in;

  // Classify the incoming tick
  always_comb begin
    tick_in.cmd      = s_axis_tuser[0];
    tick_in.op       = op_e'(s_axis_tuser[2:1]);
    tick_in.tx_byte  = s_axis_tdata[7:0];
    tick_in.send_ack = s_axis_tdata[8];
    tick_in.sda_in   = s_axis_tdata[9];
  end

  assign full          = (level_q == QLvlW'(QDepth));
  assign s_axis_tready = !full;
  assign push          = s_axis_tvalid && !full;
  assign tick_valid_o  = (level_q != '0);
  assign tick_o        = mem_q[rd_ptr_q];
  assign stat_o.level  = level_q;
  assign stat_o.full   = full;

  // Advance queue pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop_i) begin
        level_q <= level_q + 1'b1;
      end else if (!push && pop_i) begin
        level_q <= level_q - 1'b1;
      end
    end
  end

  // Store the transfer payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= tick_in;
    end
  end

endmodule

// ===== rtl/i2cm_seq.sv =====
// ----------------------------------------------------------------------------
// I2C master bus sequencer
// Steps the pin phase machine once per queued tick and registers the result
// for the output stream. Also holds the configuration registers.
// ----------------------------------------------------------------------------
module i2cm_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  i2cm_pkg::tick_t               tick_i,
  input  logic                          tick_valid_i,
  output logic                          pop_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [i2cm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [i2cm_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output i2cm_pkg::res_t                res_o
);
  import i2cm_pkg::*;

  typedef enum logic [3:0] {
    PhIdle   = 4'd0,
    PhStHi   = 4'd1,
    PhStLo   = 4'd2,
    PhSpA    = 4'd3,
    PhSpB    = 4'd4,
    PhSpC    = 4'd5,
    PhWLow   = 4'd6,
    PhWHigh  = 4'd7,
    PhWPoll  = 4'd8,
    PhWAckHi = 4'd9,
    PhWNakHi = 4'd10,
    PhRLow   = 4'd11,
    PhRHigh  = 4'd12,
    PhRaLow  = 4'd13,
    PhRaHigh = 4'd14
  } phase_e;

  logic [15:0] half_q;
  logic [7:0]  poll_lim_q;

  phase_e      phase_q, phase_d;
  logic [15:0] hold_q, hold_d;
  logic [3:0]  bits_q, bits_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  poll_q, poll_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        ack_q, ack_d;
  logic        nack_q, nack_d;
  logic [7:0]  rx_q, rx_d;
  logic        done;

  logic        out_valid_q;
  res_t        res_q;
  logic        step;

  logic [15:0] hp;
  logic [7:0]  lim;
  logic [7:0]  poll_inc;
  logic [3:0]  bits_inc;
  logic [7:0]  shift_sl;

  assign step        = tick_valid_i && (!out_valid_q || m_axis_tready);
  assign pop_o       = step;
  assign cfg_ready_o = 1'b1;

  assign hp       = (half_q == '0) ? 16'd1 : half_q;
  assign lim      = (poll_lim_q == '0) ? 8'd1 : poll_lim_q;
  assign poll_inc = poll_q + 8'd1;
  assign bits_inc = bits_q + 4'd1;
  assign shift_sl = {shift_q[6:0], 1'b0};

  // Work out the next phase and pin levels for one tick
  always_comb begin
    phase_d = phase_q;
    hold_d  = hold_q;
    bits_d  = bits_q;
    shift_d = shift_q;
    poll_d  = poll_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    ack_d   = ack_q;
    nack_d  = nack_q;
    rx_d    = rx_q;
    done    = 1'b0;

    if (phase_q == PhIdle) begin
      if (tick_i.cmd) begin
        nack_d = 1'b0;
        hold_d = hp;
        case (tick_i.op)
          OpStart: begin
            phase_d = PhStHi;
            scl_d   = 1'b1;
            sda_d   = 1'b1;
          end
          OpStop: begin
            phase_d = PhSpA;
            sda_d   = 1'b0;
          end
          OpWrite: begin
            shift_d = tick_i.tx_byte;
            bits_d  = '0;
            phase_d = PhWLow;
            scl_d   = 1'b0;
            sda_d   = tick_i.tx_byte[7];
          end
          OpRead: begin
            ack_d   = tick_i.send_ack;
            shift_d = '0;
            bits_d  = '0;
            phase_d = PhRLow;
            scl_d   = 1'b0;
            sda_d   = 1'b1;
          end
          default: begin
            phase_d = PhIdle;
          end
        endcase
      end
    end else if (phase_q == PhWPoll) begin
      // Sample for ACK once per tick until the limit runs out
      if (!tick_i.sda_in) begin
        phase_d = PhWAckHi;
        scl_d   = 1'b1;
        sda_d   = 1'b1;
        hold_d  = hp;
      end else begin
        poll_d = poll_inc;
        if (poll_inc >= lim) begin
          phase_d = PhWNakHi;
          scl_d   = 1'b1;
          sda_d   = 1'b1;
          hold_d  = hp;
        end
      end
    end else if (hold_q > 16'd1) begin
      hold_d = hold_q - 16'd1;
    end else begin
      hold_d = '0;
      case (phase_q)
        PhStHi: begin
          phase_d = PhStLo;
          scl_d   = 1'b1;
          sda_d   = 1'b0;
          hold_d  = hp;
        end
        PhStLo: begin
          scl_d = 1'b0;
          done  = 1'b1;
        end
        PhSpA: begin
          phase_d = PhSpB;
          scl_d   = 1'b1;
          sda_d   = 1'b0;
          hold_d  = hp;
        end
        PhSpB: begin
          phase_d = PhSpC;
          scl_d   = 1'b1;
          sda_d   = 1'b1;
          hold_d  = hp;
        end
        PhSpC: begin
          done = 1'b1;
        end
        PhWLow: begin
          phase_d = PhWHigh;
          scl_d   = 1'b1;
          hold_d  = hp;
        end
        PhWHigh: begin
          shift_d = shift_sl;
          bits_d  = bits_inc;
          if (bits_inc[3]) begin
            scl_d   = 1'b0;
            sda_d   = 1'b1;
            poll_d  = '0;
            phase_d = PhWPoll;
          end else begin
            phase_d = PhWLow;
            scl_d   = 1'b0;
            sda_d   = shift_sl[7];
            hold_d  = hp;
          end
        end
        PhWAckHi: begin
          scl_d = 1'b0;
          done  = 1'b1;
        end
        PhWNakHi: begin
          nack_d  = 1'b1;
          phase_d = PhSpA;
          scl_d   = 1'b0;
          sda_d   = 1'b0;
          hold_d  = hp;
        end
        PhRLow: begin
          scl_d  = 1'b0;
          hold_d = hp;
          if (bits_q[3]) begin
            phase_d = PhRaLow;
            sda_d   = !ack_q;
          end else begin
            phase_d = PhRHigh;
            scl_d   = 1'b1;
            sda_d   = 1'b1;
          end
        end
        PhRHigh: begin
          shift_d = {shift_q[6:0], tick_i.sda_in};
          bits_d  = bits_inc;
          phase_d = PhRLow;
          scl_d   = 1'b0;
          sda_d   = 1'b1;
          hold_d  = hp;
        end
        PhRaLow: begin
          phase_d = PhRaHigh;
          scl_d   = 1'b1;
          hold_d  = hp;
        end
        PhRaHigh: begin
          scl_d = 1'b0;
          sda_d = 1'b1;
          rx_d  = shift_q;
          done  = 1'b1;
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end

    // Return to idle when the command completes
    if (done) begin
      phase_d = PhIdle;
      hold_d  = '0;
    end
  end

  // Hold sequencer state and the output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      hold_q      <= '0;
      bits_q      <= '0;
      shift_q     <= '0;
      poll_q      <= '0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      ack_q       <= 1'b0;
      nack_q      <= 1'b0;
      rx_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        phase_q     <= phase_d;
        hold_q      <= hold_d;
        bits_q      <= bits_d;
        shift_q     <= shift_d;
        poll_q      <= poll_d;
        scl_q       <= scl_d;
        sda_q       <= sda_d;
        ack_q       <= ack_d;
        nack_q      <= nack_d;
        rx_q        <= rx_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Register the result of each stepped tick
  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q.scl_out  <= scl_d;
      res_q.sda_out  <= sda_d;
      res_q.busy_res <= (phase_d != PhIdle);
      res_q.done_res <= done;
      res_q.status   <= nack_d;
      res_q.rx_byte  <= rx_d;
    end
  end

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q     <= HalfPeriodRst;
      poll_lim_q <= AckPollRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgHalfPeriod: half_q     <= cfg_data_i;
        CfgAckPoll:    poll_lim_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign res_o         = res_q;

endmodule

// ===== rtl/i2c_master_byte_engine.sv =====
// ----------------------------------------------------------------------------
// I2C master byte engine
// Each input transfer is one timing tick, optionally carrying a command
// (start, stop, write byte, read byte) plus the sampled SDA level. Each tick
// yields one output transfer with the SCL/SDA pin levels, busy, done, the
// write ACK status and the last received byte.
//
// Channels: s_axis carries ticks in, m_axis carries results out, cfg writes
// half_period_ticks (index 0) and ack_poll_limit (index 1); cfg is always
// ready; the user must write it only while the engine is idle, which the
// block itself does not enforce. An accepted tick is written into the tick
// queue and then stepped into the result register, which drives m_axis;
// older queued ticks or an m_axis stall can hold it in the queue.
// Throughput: one tick per cycle while m_axis is not stalled; the sequencer
// steps once per tick, behind a two-entry queue from the front end.
// Reset: pins released high, engine idle, registers back to 5 and 32.
// Stall: when m_axis_tready is low the result register holds, the queue
// fills to two ticks and then s_axis_tready drops.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: tx_byte[7:0], send_ack[8], sda_in[9], zero fill [15:10]
  input  logic [i2cm_pkg::InDataW-1:0]  s_axis_tdata,
  // tuser: cmd_valid[0], operation[2:1]
  input  logic [i2cm_pkg::InUserW-1:0]  s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: scl_out[0], sda_out[1], busy_res[2], done_res[3], status[4],
  //        rx_byte[12:5], zero fill [15:13]
  output logic [i2cm_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [i2cm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [i2cm_pkg::CfgDataW-1:0] cfg_data_i
);
  import i2cm_pkg::*;

  tick_t   tick;
  logic    tick_valid;
  logic    pop;
  q_stat_t q_stat;
  res_t    res;

  // Accept and queue ticks
  i2cm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .tick_o        (tick),
    .tick_valid_o  (tick_valid),
    .pop_i         (pop),
    .stat_o        (q_stat)
  );

  // Step the bus sequencer
  i2cm_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_i        (tick),
    .tick_valid_i  (tick_valid),
    .pop_o         (pop),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .res_o         (res)
  );

  assign m_axis_tdata = {{(OutDataW - $bits(res_t)){1'b0}}, res};

`ifndef NO_ASSERTIONS
  // A push without a pop grows the queue by one
  a_q_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !pop |=> q_stat.level == $past(q_stat.level) + 1'b1)
    else $error("tick queue level did not grow on push");

  // The sequencer never steps while a result waits on a stalled output
  a_no_step_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !pop)
    else $error("sequencer stepped over a stalled result");

  // A completing command reports not busy
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[DoneBit] |-> !m_axis_tdata[BusyBit])
    else $error("done reported while busy");

  // A popped tick always produces a result on the next cycle
  a_pop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> m_axis_tvalid)
    else $error("stepped tick produced no result");
`endif

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// I2C master byte engine testbench
// Feeds one timing tick per input transfer, sometimes carrying a start, stop,
// write or read command, and checks every result transfer (pin levels, busy,
// done, ACK status, received byte) against a tick-accurate model of the
// sequencer. Runs a directed opening, then random bus transactions under
// several half-period and ACK-poll settings, with random stalls on both
// streams.
// ----------------------------------------------------------------------------
module tb_top;
  import i2cm_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgSpareIdx = 4'd9;
  localparam int unsigned        ShowMax     = 10;

  // Sequencer steps of the engine
  typedef enum logic [3:0] {
    SeqIdle, SeqStartHi, SeqStartLo, SeqStopA, SeqStopB, SeqStopC,
    SeqWrLow, SeqWrHigh, SeqWrPoll, SeqWrAckHi, SeqWrNakHi,
    SeqRdLow, SeqRdHigh, SeqRdAckLow, SeqRdAckHigh
  } seq_e;

  // How the slave side drives SDA during a command
  typedef enum int {SdaRand, SdaLow, SdaHigh, SdaLate} sda_mode_e;

  // --------------------------------------------------------------------------
  // Pin-level model of the engine plus the queue of expected results
  // --------------------------------------------------------------------------
  class engine_tracker;
    logic [15:0] half_ticks;
    logic [7:0]  poll_lim;
    seq_e        seq;
    logic [15:0] hold;
    logic [3:0]  nbits;
    logic [7:0]  shreg;
    logic [7:0]  polls;
    logic [7:0]  rx;
    logic        scl;
    logic        sda;
    logic        ack_sel;
    logic        nack;
    res_t        pending_pins[$];
    int          mismatches;
    int          checked;
    int          acked;
    int          nacked;

    function new();
      half_ticks = HalfPeriodRst;
      poll_lim   = AckPollRst;
      seq        = SeqIdle;
      hold       = '0;
      nbits      = '0;
      shreg      = '0;
      polls      = '0;
      rx         = '0;
      scl        = 1'b1;
      sda        = 1'b1;
      ack_sel    = 1'b0;
      nack       = 1'b0;
      mismatches = 0;
      checked    = 0;
      acked      = 0;
      nacked     = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      if (idx == CfgHalfPeriod) begin
        half_ticks = val;
      end else if (idx == CfgAckPoll) begin
        poll_lim = val[7:0];
      end
    endfunction

    // Enter a step: new pins show at once, hold timer restarts
    function void go(seq_e s, logic c, logic d);
      seq  = s;
      scl  = c;
      sda  = d;
      hold = (half_ticks == 0) ? 16'd1 : half_ticks;
    endfunction

    function void accept(tick_t t);
      nack = 1'b0;
      case (t.op)
        OpStart: go(SeqStartHi, 1'b1, 1'b1);
        OpStop:  go(SeqStopA, scl, 1'b0);
        OpWrite: begin
          shreg = t.tx_byte;
          nbits = '0;
          go(SeqWrLow, 1'b0, shreg[7]);
        end
        default: begin
          ack_sel = t.send_ack;
          shreg   = '0;
          nbits   = '0;
          go(SeqRdLow, 1'b0, 1'b1);
        end
      endcase
    endfunction

    // Advance one tick while busy; return 1 when the command completes
    function bit advance(logic sin);
      logic [7:0] lim;
      if (seq == SeqWrPoll) begin
        if (!sin) begin
          go(SeqWrAckHi, 1'b1, 1'b1);
        end else begin
          lim   = (poll_lim == 0) ? 8'd1 : poll_lim;
          polls = polls + 8'd1;
          if (polls >= lim) go(SeqWrNakHi, 1'b1, 1'b1);
        end
        return 1'b0;
      end
      if (hold > 1) begin
        hold = hold - 16'd1;
        return 1'b0;
      end
      hold = '0;
      case (seq)
        SeqStartHi: go(SeqStartLo, 1'b1, 1'b0);
        SeqStartLo: begin
          scl = 1'b0;
          return 1'b1;
        end
        SeqStopA: go(SeqStopB, 1'b1, 1'b0);
        SeqStopB: go(SeqStopC, 1'b1, 1'b1);
        SeqStopC: return 1'b1;
        SeqWrLow: go(SeqWrHigh, 1'b1, sda);
        SeqWrHigh: begin
          shreg = shreg << 1;
          nbits = nbits + 4'd1;
          if (nbits >= 8) begin
            scl   = 1'b0;
            sda   = 1'b1;
            polls = '0;
            seq   = SeqWrPoll;
          end else begin
            go(SeqWrLow, 1'b0, shreg[7]);
          end
        end
        SeqWrAckHi: begin
          scl = 1'b0;
          acked++;
          return 1'b1;
        end
        SeqWrNakHi: begin
          nack = 1'b1;
          nacked++;
          go(SeqStopA, 1'b0, 1'b0);
        end
        SeqRdLow: begin
          if (nbits >= 8) go(SeqRdAckLow, 1'b0, !ack_sel);
          else go(SeqRdHigh, 1'b1, 1'b1);
        end
        SeqRdHigh: begin
          shreg = {shreg[6:0], sin};
          nbits = nbits + 4'd1;
          go(SeqRdLow, 1'b0, 1'b1);
        end
        SeqRdAckLow: go(SeqRdAckHigh, 1'b1, sda);
        SeqRdAckHigh: begin
          scl = 1'b0;
          sda = 1'b1;
          rx  = shreg;
          return 1'b1;
        end
        default: return 1'b1;
      endcase
      return 1'b0;
    endfunction

    // Note one accepted tick and queue the result it yields
    function void take_tick(tick_t t);
      bit   fin;
      res_t r;
      fin = 1'b0;
      if (seq == SeqIdle) begin
        if (t.cmd) accept(t);
      end else if (advance(t.sda_in)) begin
        fin  = 1'b1;
        seq  = SeqIdle;
        hold = '0;
      end
      r.scl_out  = scl;
      r.sda_out  = sda;
      r.busy_res = (seq != SeqIdle);
      r.done_res = fin;
      r.status   = nack;
      r.rx_byte  = rx;
      pending_pins.push_back(r);
    endfunction

    // Compare one result transfer with the oldest expectation
    function void match_result(logic [OutDataW-1:0] d);
      res_t got;
      res_t want;
      got = d[$bits(res_t)-1:0];
      checked++;
      if (pending_pins.size() == 0) begin
        mismatches++;
        if (mismatches <= ShowMax)
          $display("%0t: result %h arrived with nothing expected", $time, d);
        return;
      end
      want = pending_pins.pop_front();
      if (got.scl_out !== want.scl_out || got.sda_out !== want.sda_out ||
          got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
          got.status !== want.status || got.rx_byte !== want.rx_byte ||
          d[OutDataW-1:$bits(res_t)] !== '0) begin
        mismatches++;
        if (mismatches <= ShowMax) begin
          $display("%0t: result %0d expected scl %b sda %b busy %b done %b status %b rx %h",
                   $time, checked, want.scl_out, want.sda_out, want.busy_res,
                   want.done_res, want.status, want.rx_byte);
          $display("%0t: result %0d got scl %b sda %b busy %b done %b status %b rx %h fill %b",
                   $time, checked, got.scl_out, got.sda_out, got.busy_res,
                   got.done_res, got.status, got.rx_byte, d[OutDataW-1:$bits(res_t)]);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block under test
  // --------------------------------------------------------------------------
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [InUserW-1:0]  s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b1;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  engine_tracker book = new();
  bit            gaps_on = 1'b1;
  int            cmds_issued = 0;
  int            ticks_sent = 0;
  int            op_seen[4] = '{0, 0, 0, 0};

  always #6 clk_i = ~clk_i;

  i2c_master_byte_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    // tdata: tx_byte[7:0], send_ack[8], sda_in[9], zero fill [15:10]
    .s_axis_tdata  (s_axis_tdata),
    // tuser: cmd_valid[0], operation[2:1]
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // tdata: scl_out[0], sda_out[1], busy_res[2], done_res[3], status[4],
    //        rx_byte[12:5], zero fill [15:13]
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Result side: check each transfer, stall in random bursts
  // --------------------------------------------------------------------------
  initial begin : result_side
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) book.match_result(m_axis_tdata);
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) m_axis_tready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 11);
        m_axis_tready <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tick side helpers
  // --------------------------------------------------------------------------
  // Drive one tick, hold until the transfer, then update the model
  task automatic send_tick(tick_t t);
    if (gaps_on && $urandom_range(0, 11) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, t.sda_in, t.send_ack, t.tx_byte};
    s_axis_tuser  <= {t.op, t.cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    book.take_tick(t);
    ticks_sent++;
  endtask

  // Random tick; noise is the percent chance of a stray command flag
  function automatic tick_t rand_tick(sda_mode_e m, int noise);
    tick_t t;
    t.cmd      = ($urandom_range(0, 99) < noise);
    t.op       = op_e'($urandom_range(0, 3));
    t.tx_byte  = 8'($urandom_range(0, 255));
    t.send_ack = 1'($urandom_range(0, 1));
    case (m)
      SdaLow:  t.sda_in = 1'b0;
      SdaHigh: t.sda_in = 1'b1;
      SdaLate: t.sda_in = ($urandom_range(0, 19) != 0);
      default: t.sda_in = 1'($urandom_range(0, 1));
    endcase
    return t;
  endfunction

  // Issue one command on an idle engine and tick it to completion
  task automatic run_cmd(op_e op, logic [7:0] data, logic ack, sda_mode_e m, int noise);
    tick_t t;
    while (book.seq != SeqIdle) send_tick(rand_tick(m, noise));
    t          = rand_tick(m, 0);
    t.cmd      = 1'b1;
    t.op       = op;
    t.tx_byte  = data;
    t.send_ack = ack;
    send_tick(t);
    cmds_issued++;
    op_seen[op]++;
    // stray commands while busy must be dropped
    while (book.seq != SeqIdle) send_tick(rand_tick(m, noise));
    repeat ($urandom_range(0, 2)) send_tick(rand_tick(m, 0));
  endtask

  // Start, one or two byte transfers, stop
  task automatic run_transfer(int noise);
    int n;
    n = $urandom_range(1, 2);
    run_cmd(OpStart, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), SdaRand, noise);
    repeat (n) begin
      if ($urandom_range(0, 1))
        run_cmd(OpWrite, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                sda_mode_e'($urandom_range(0, 3)), noise);
      else
        run_cmd(OpRead, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                SdaRand, noise);
    end
    run_cmd(OpStop, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), SdaRand, noise);
  endtask

  // Mostly well-formed transactions, some lone commands in any order,
  // until about quota ticks have been sent
  task automatic run_phase(int quota, int noise, bit quiet);
    int first;
    first = ticks_sent;
    while (ticks_sent - first < quota) begin
      gaps_on = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 5) == 0)
        run_cmd(op_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)), sda_mode_e'($urandom_range(0, 3)), noise);
      else
        run_transfer(noise);
    end
  endtask

  // One register write; valid stays high for back-to-back writes
  task automatic cfg_put(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    book.set_reg(idx, val);
  endtask

  // Drain all results, then rewrite both registers on the idle engine
  task automatic reconfigure(logic [15:0] hp, logic [15:0] lim_word, bit poke_spare);
    s_axis_tvalid <= 1'b0;
    while (book.pending_pins.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (poke_spare) cfg_put(CfgSpareIdx, 16'($urandom_range(0, 65535)));
    cfg_put(CfgHalfPeriod, hp);
    cfg_put(CfgAckPoll, lim_word);
    cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening at reset register values
    run_cmd(OpStop,  8'h00, 1'b0, SdaRand, 30);  // stop with SCL still high
    run_cmd(OpStart, 8'hFF, 1'b1, SdaRand, 30);
    run_cmd(OpWrite, 8'h00, 1'b0, SdaLow,  30);  // ACK on first poll tick
    run_cmd(OpStop,  8'hC3, 1'b0, SdaRand, 30);

    // Directed commands at the shortest half period
    reconfigure(16'd1, 16'd3, 1'b0);
    run_cmd(OpWrite, 8'hFF, 1'b1, SdaHigh, 30);  // no ACK, stop follows
    run_cmd(OpStart, 8'h00, 1'b0, SdaRand, 30);
    run_cmd(OpWrite, 8'hA5, 1'b0, SdaLate, 30);
    run_cmd(OpWrite, 8'h5A, 1'b1, SdaRand, 30);
    run_cmd(OpRead,  8'hFF, 1'b1, SdaRand, 30);
    run_cmd(OpRead,  8'h00, 1'b0, SdaHigh, 30);
    run_cmd(OpRead,  8'h3C, 1'b1, SdaLow,  30);
    run_cmd(OpStop,  8'hC3, 1'b0, SdaRand, 30);
    run_cmd(OpStart, 8'h81, 1'b1, SdaRand, 30);
    run_cmd(OpStart, 8'h7E, 1'b0, SdaRand, 30);  // repeated start
    run_cmd(OpRead,  8'h18, 1'b0, SdaRand, 30);
    run_cmd(OpStop,  8'hE7, 1'b1, SdaRand, 30);
    run_cmd(OpStop,  8'h24, 1'b0, SdaRand, 30);

    // Random transactions across register settings
    reconfigure(16'd1, 16'd1, 1'b0);
    run_phase(60, 20, 1'b0);
    reconfigure(16'd0, 16'hFF00, 1'b1);          // both zero, act as one
    run_phase(60, 20, 1'b0);
    reconfigure(16'd2, 16'd9, 1'b0);
    run_phase(60, 20, 1'b0);
    reconfigure(16'd3, 16'd7, 1'b1);
    run_phase(60, 20, 1'b0);

    // Longer half period: a single start, no stalls
    gaps_on = 1'b0;
    reconfigure(16'd40, 16'd2, 1'b0);
    run_cmd(OpStart, 8'h55, 1'b1, SdaRand, 10);

    reconfigure(16'($urandom_range(1, 4)), 16'($urandom_range(1, 12)), 1'b0);
    run_phase(60, 20, 1'b0);
    reconfigure(16'd1, 16'd4, 1'b0);
    run_phase(60, 20, 1'b1);

    // Drain and report
    s_axis_tvalid <= 1'b0;
    while (book.pending_pins.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Ran %0d commands (start %0d, stop %0d, write %0d, read %0d), %0d ticks checked",
             cmds_issued, op_seen[OpStart], op_seen[OpStop], op_seen[OpWrite],
             op_seen[OpRead], book.checked);
    $display("Writes acknowledged %0d, writes without ACK %0d, mismatches %0d",
             book.acked, book.nacked, book.mismatches);
    if (book.mismatches == 0) begin
      $display("** i2c_master_byte_engine: PASSED **");
    end else begin
      $display("** i2c_master_byte_engine: FAILED **");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin : watchdog
    #(2_000_000);
    $display("timeout with %0d results still expected", book.pending_pins.size());
    $display("** i2c_master_byte_engine: FAILED **");
    $finish;
  end

endmodule
